// ===== hw/rtl/stsm_pkg.sv =====
// Shared constants and node type for the segment tree sum / suffix-max block.
package stsm_pkg;

  // Tree shape: number of leaves, a power of two.
  localparam int LEAVES = 1024;
  localparam int LVL_W  = $clog2(LEAVES);
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int ADDR_W = LVL_W + 1;   // zero-based heap address
  localparam int POS_W  = LVL_W + 2;   // one-based heap position, holds 2*LEAVES

  // Field widths.
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int LO_W  = 10;
  localparam int HI_W  = 11;
  localparam int ACC_W = 42;

  // Operation codes.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] best;
  } node_t;

endpackage

// ===== hw/rtl/stsm_if.sv =====
// Valid/ready channel interfaces for input words and result words.
interface stsm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [stsm_pkg::IDX_W-1:0]       index;
  logic signed [stsm_pkg::VAL_W-1:0] value;
  logic [stsm_pkg::LO_W-1:0]        lo;
  logic [stsm_pkg::HI_W-1:0]        hi;

  modport source (output valid, op, index, value, lo, hi, input ready);
  modport sink   (input valid, op, index, value, lo, hi, output ready);
endinterface

interface stsm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [stsm_pkg::ACC_W-1:0] range_sum;
  logic signed [stsm_pkg::ACC_W-1:0] best_suffix;

  modport source (output valid, range_sum, best_suffix, input ready);
  modport sink   (input valid, range_sum, best_suffix, output ready);
endinterface

// ===== hw/rtl/stsm_combine.sv =====
// Node merge: sum of both halves and best suffix of the left-then-right span.
module stsm_combine (
  input  stsm_pkg::node_t left_node,
  input  stsm_pkg::node_t right_node,
  output stsm_pkg::node_t merged
);

  logic signed [stsm_pkg::ACC_W-1:0] cand;
  logic signed [stsm_pkg::ACC_W-1:0] rbest;

  assign cand  = right_node.sum + left_node.best;
  assign rbest = right_node.best;

  assign merged.sum  = left_node.sum + right_node.sum;
  assign merged.best = (cand > rbest) ? cand : rbest;

endmodule

// ===== hw/rtl/segment_tree_sum_suffix_max.sv =====
// Top level: segment tree of sums and best suffixes held in one node memory.
//
//  channel | dir | handshake         | word
//  --------+-----+-------------------+-------------------------------------
//  in_ch   | in  | valid/ready       | op, index, value, lo, hi
//  out_ch  | out | valid/ready       | range_sum, best_suffix (queries only)
//
// An update writes one leaf, then does a sibling read and a parent write
// per level of the tree. A query, at each level, reads the two boundary
// nodes on the two read ports and merges them. The node memory has a
// single write port and registered read ports. Reset starts a clearing
// pass that writes zeros into every node; in_ch.ready stays low meanwhile.
// A finished result waits in the output register; new words are taken
// while it waits, and only a second result stalls behind an unread one.
module segment_tree_sum_suffix_max (
  input  logic         clk,
  input  logic         rst_n,
  stsm_in_if.sink      in_ch,
  stsm_out_if.source   out_ch
);

  localparam int AW = stsm_pkg::ADDR_W;
  localparam int PW = stsm_pkg::POS_W;
  localparam int AC = stsm_pkg::ACC_W;
  localparam int VW = stsm_pkg::VAL_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_LEAF  = 9'b000000100,
    S_URD   = 9'b000001000,
    S_UWR   = 9'b000010000,
    S_QRD   = 9'b000100000,
    S_QACC  = 9'b001000000,
    S_QFIN  = 9'b010000000,
    S_QPRM  = 9'b100000000
  } state_t;

  // Control state.
  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic            resl_vld_r, resl_vld_nxt;

  // Datapath registers.
  logic [AW-1:0]   pos_r, pos_nxt;
  stsm_pkg::node_t cur_r, cur_nxt;
  logic [PW-1:0]   l_r, l_nxt;
  logic [PW-1:0]   r_r, r_nxt;
  stsm_pkg::node_t resl_r, resl_nxt;
  stsm_pkg::node_t resr_r, resr_nxt;
  stsm_pkg::node_t fin_r, fin_nxt;
  logic            lo_nz_r, lo_nz_nxt;
  logic [VW-1:0]   val_r, val_nxt;
  logic [AC-1:0]   out_sum_r, out_sum_nxt;
  logic [AC-1:0]   out_best_r, out_best_nxt;

  // Node memory: one write port, two registered read ports.
  stsm_pkg::node_t node_mem [stsm_pkg::NODES];
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  stsm_pkg::node_t mem_wd;
  logic            rd_en;
  logic [AW-1:0]   ra_a, ra_b;
  stsm_pkg::node_t rd_a_r, rd_b_r;

  // Merge units.
  stsm_pkg::node_t upd_left, upd_right, upd_node;
  stsm_pkg::node_t ql_node, qr_node, fin_node;

  // Helpers.
  logic            in_acc;
  logic [AW-1:0]   sib_addr, par_addr;
  logic [PW-1:0]   l_dec, r_dec2, l_step, r_step, hi_clamp;
  stsm_pkg::node_t leaf_node;
  logic signed [AC-1:0] prm_best;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid       = out_vld_r;
  assign out_ch.range_sum   = out_sum_r;
  assign out_ch.best_suffix = out_best_r;

  // Sibling and parent in zero-based heap order: odd addresses are left children.
  assign sib_addr = pos_r[0] ? pos_r + AW'(1) : pos_r - AW'(1);
  assign par_addr = (pos_r - AW'(1)) >> 1;

  assign upd_left  = pos_r[0] ? cur_r  : rd_a_r;
  assign upd_right = pos_r[0] ? rd_a_r : cur_r;

  stsm_combine u_cmb_upd (.left_node(upd_left), .right_node(upd_right), .merged(upd_node));
  stsm_combine u_cmb_ql  (.left_node(resl_r),   .right_node(rd_a_r),    .merged(ql_node));
  stsm_combine u_cmb_qr  (.left_node(rd_b_r),   .right_node(resr_r),    .merged(qr_node));
  stsm_combine u_cmb_fin (.left_node(resl_r),   .right_node(resr_r),    .merged(fin_node));

  // One-based boundary positions map to zero-based addresses l-1 and r-2.
  assign l_dec  = l_r - PW'(1);
  assign r_dec2 = r_r - PW'(2);
  assign l_step = (l_r + PW'(l_r[0])) >> 1;
  assign r_step = (r_r - PW'(r_r[0])) >> 1;

  assign hi_clamp = (32'(in_ch.hi) > 32'(stsm_pkg::LEAVES)) ?
                    PW'(stsm_pkg::LEAVES) : PW'(in_ch.hi);

  assign leaf_node.sum  = {{(AC-VW){val_r[VW-1]}}, val_r};
  assign leaf_node.best = '0;

  // A disjoint span left of the range merges in as zero and lets the full
  // range count as a suffix.
  assign prm_best = (lo_nz_r && (fin_r.sum > fin_r.best)) ? fin_r.sum : fin_r.best;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    out_vld_nxt  = out_vld_r;
    resl_vld_nxt = resl_vld_r;
    pos_nxt      = pos_r;
    cur_nxt      = cur_r;
    l_nxt        = l_r;
    r_nxt        = r_r;
    resl_nxt     = resl_r;
    resr_nxt     = resr_r;
    fin_nxt      = fin_r;
    lo_nz_nxt    = lo_nz_r;
    val_nxt      = val_r;
    out_sum_nxt  = out_sum_r;
    out_best_nxt = out_best_r;
    mem_we       = 1'b0;
    mem_wa       = pos_r;
    mem_wd       = leaf_node;
    rd_en        = 1'b0;
    ra_a         = sib_addr;
    ra_b         = r_dec2[AW-1:0];

    // Drop the result word once taken.
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(stsm_pkg::NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          val_nxt = in_ch.value;
          if (in_ch.op == stsm_pkg::OP_UPDATE) begin
            // Ignore a leaf index past the tree.
            if (32'(in_ch.index) < 32'(stsm_pkg::LEAVES)) begin
              pos_nxt   = AW'(stsm_pkg::LEAVES - 1) + AW'(in_ch.index);
              state_nxt = S_LEAF;
            end
          end else begin
            lo_nz_nxt    = (in_ch.lo != '0);
            resl_vld_nxt = 1'b0;
            resr_nxt     = '0;
            if (32'(in_ch.lo) < 32'(stsm_pkg::LEAVES)) begin
              l_nxt = PW'(in_ch.lo) + PW'(stsm_pkg::LEAVES);
              r_nxt = hi_clamp + PW'(stsm_pkg::LEAVES);
            end else begin
              l_nxt = '0;
              r_nxt = '0;
            end
            state_nxt = S_QRD;
          end
        end
      end
      S_LEAF: begin
        mem_we  = 1'b1;
        mem_wa  = pos_r;
        mem_wd  = leaf_node;
        cur_nxt = leaf_node;
        state_nxt = (pos_r == '0) ? S_IDLE : S_URD;
      end
      S_URD: begin
        rd_en     = 1'b1;
        ra_a      = sib_addr;
        state_nxt = S_UWR;
      end
      S_UWR: begin
        mem_we  = 1'b1;
        mem_wa  = par_addr;
        mem_wd  = upd_node;
        cur_nxt = upd_node;
        pos_nxt = par_addr;
        state_nxt = (par_addr == '0) ? S_IDLE : S_URD;
      end
      S_QRD: begin
        if (l_r < r_r) begin
          rd_en     = 1'b1;
          ra_a      = l_dec[AW-1:0];
          ra_b      = r_dec2[AW-1:0];
          state_nxt = S_QACC;
        end else begin
          state_nxt = S_QFIN;
        end
      end
      S_QACC: begin
        // Fold in the left boundary node when l is a right child, and the
        // right boundary node when r is a right child.
        if (l_r[0]) begin
          resl_nxt     = resl_vld_r ? ql_node : rd_a_r;
          resl_vld_nxt = 1'b1;
        end
        if (r_r[0]) begin
          resr_nxt = qr_node;
        end
        l_nxt     = l_step;
        r_nxt     = r_step;
        state_nxt = S_QRD;
      end
      S_QFIN: begin
        fin_nxt   = resl_vld_r ? fin_node : resr_r;
        state_nxt = S_QPRM;
      end
      S_QPRM: begin
        // Hold until the output register is free.
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt  = 1'b1;
          out_sum_nxt  = fin_r.sum;
          out_best_nxt = prm_best;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      out_vld_r  <= 1'b0;
      resl_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      out_vld_r  <= out_vld_nxt;
      resl_vld_r <= resl_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    resl_r     <= resl_nxt;
    resr_r     <= resr_nxt;
    fin_r      <= fin_nxt;
    lo_nz_r    <= lo_nz_nxt;
    val_r      <= val_nxt;
    out_sum_r  <= out_sum_nxt;
    out_best_r <= out_best_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_a_r <= node_mem[ra_a];
      rd_b_r <= node_mem[ra_b];
    end
  end

endmodule

// ===== hw/rtl/stsm_checker.sv =====
// Port-level checks for the segment tree block, bound to the top level.
module stsm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_op,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [stsm_pkg::ACC_W-1:0]   range_sum,
  input logic [stsm_pkg::ACC_W-1:0]   best_suffix
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(range_sum) && $stable(best_suffix))
    else $error("result word changed or dropped while stalled");

  // Best suffix includes the empty suffix, so it is never negative.
  a_best_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !best_suffix[stsm_pkg::ACC_W-1])
    else $error("negative best suffix");

  // Reset starts the clearing pass; no word is taken right after it.
  a_reset_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  // An update never raises a result.
  a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == stsm_pkg::OP_UPDATE) && !out_valid |=> !out_valid)
    else $error("update produced a result word");

  // One word at a time: the block is busy the cycle after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken back to back");

endmodule

bind segment_tree_sum_suffix_max stsm_checker u_stsm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_op       (in_ch.op),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .range_sum   (out_ch.range_sum),
  .best_suffix (out_ch.best_suffix)
);
